/* hdl/lpd_pkg.sv */
// Shared types and constants for the length-prefix deframer.
// No dependencies; used by lpd_front, lpd_queue and the top level.
package lpd_pkg;

   localparam int unsigned HEADER_BYTES = 4;
   localparam logic [31:0] DEFAULT_MAX_FRAME_LENGTH = 32'd33554432;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_OVERSIZE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic       last_in_frame;
   } result_type;

endpackage

/* hdl/lpd_front.sv */
// Front end: header assembly, length check and payload tracking, one accepted item a cycle.
// Depends on lpd_pkg. Emits at most one result per accepted item.
module lpd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data,
   output logic               result_valid,
   output lpd_pkg::result_type result
);

   localparam logic [1:0] LAST_HDR = 2'(lpd_pkg::HEADER_BYTES - 1);

   logic        in_payload_ff, in_payload_in;
   logic [1:0]  hdr_seen_ff, hdr_seen_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] max_len_ff, max_len_in;
   logic [31:0] assembled;
   logic [31:0] rem_dec;

   assign assembled = {length_ff[23:0], data_byte};
   assign rem_dec   = remaining_ff - 32'd1;

   always_comb begin
      in_payload_in = in_payload_ff;
      hdr_seen_in   = hdr_seen_ff;
      length_in     = length_ff;
      remaining_in  = remaining_ff;
      max_len_in    = csr_wr_en ? csr_wr_data : max_len_ff;
      result_valid  = 1'b0;
      result        = '{kind: lpd_pkg::KIND_PAYLOAD, payload_byte: 8'd0, last_in_frame: 1'b0};
      if (accept) begin
         if (in_payload_ff) begin
            remaining_in         = rem_dec;
            result_valid         = 1'b1;
            result.payload_byte  = data_byte;
            result.last_in_frame = (rem_dec == 32'd0);
            if (rem_dec == 32'd0) begin
               in_payload_in = 1'b0;
            end
         end else begin
            length_in = assembled;
            if (hdr_seen_ff != LAST_HDR) begin
               hdr_seen_in = hdr_seen_ff + 2'd1;
            end else begin
               hdr_seen_in  = 2'd0;
               priority if (assembled > max_len_ff) begin
                  length_in    = 32'd0;
                  result_valid = 1'b1;
                  result.kind  = lpd_pkg::KIND_OVERSIZE;
               end else if (assembled == 32'd0) begin
                  result_valid         = 1'b1;
                  result.kind          = lpd_pkg::KIND_EMPTY;
                  result.last_in_frame = 1'b1;
               end else begin
                  remaining_in  = assembled;
                  length_in     = 32'd0;
                  in_payload_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         hdr_seen_ff   <= 2'd0;
         length_ff     <= 32'd0;
         remaining_ff  <= 32'd0;
         max_len_ff    <= lpd_pkg::DEFAULT_MAX_FRAME_LENGTH;
      end else begin
         in_payload_ff <= in_payload_in;
         hdr_seen_ff   <= hdr_seen_in;
         length_ff     <= length_in;
         remaining_ff  <= remaining_in;
         max_len_ff    <= max_len_in;
      end
   end

   // payload results only come out of payload mode
   a_payload_mode: assert property (@(posedge clock) disable iff (reset)
      result_valid && result.kind == lpd_pkg::KIND_PAYLOAD |-> in_payload_ff)
      else $error("payload result outside payload mode");

   // final payload byte drops back to header mode
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      accept && in_payload_ff && remaining_ff == 32'd1 |=> !in_payload_ff && hdr_seen_ff == 2'd0)
      else $error("frame end did not return to header mode");

   // oversize error leaves a clean header state
   a_oversize_resync: assert property (@(posedge clock) disable iff (reset)
      result_valid && result.kind == lpd_pkg::KIND_OVERSIZE
      |=> !in_payload_ff && hdr_seen_ff == 2'd0 && length_ff == 32'd0)
      else $error("oversize error did not resync header");

endmodule

/* hdl/lpd_queue.sv */
// Result queue between the front end and the consumer.
// Depends on lpd_pkg for the result item type.
module lpd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lpd_pkg::result_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output lpd_pkg::result_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lpd_pkg::result_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full   = (count_ff == CNT_FULL);
   assign empty  = (count_ff == '0);
   assign head   = mem[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !do_pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push without pop did not grow queue");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      !push && do_pop |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop without push did not shrink queue");

endmodule

/* hdl/length_prefix_deframer_core.sv */
// Length-prefix deframer: 4-byte big-endian header, payload pass-through.
// Each result is formed combinationally from its accepted byte and written into the queue in the same cycle.
// Throughput: one byte per cycle while req_full is low, set by the header/payload tracker;
// full rises only while FIFO_DEPTH results wait unpopped.
// Reset (synchronous): header mode, counters cleared, maximum length 32 MiB, queue empty.
module length_prefix_deframer_core #(
   parameter int unsigned FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_data_byte,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_in_frame,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic                accept;
   logic                result_valid;
   lpd_pkg::result_type result;
   lpd_pkg::result_type head;

   assign accept = req_push && !req_full;

   lpd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .result_valid (result_valid),
      .result       (result)
   );

   lpd_queue #(
      .DEPTH (FIFO_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .full      (req_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (head)
   );

   assign rsp_result_kind   = head.kind;
   assign rsp_payload_byte  = head.payload_byte;
   assign rsp_last_in_frame = head.last_in_frame;

endmodule

/* tb/sv/tb_length_prefix_deframer_core.sv */
// Testbench for length_prefix_deframer_core: directed frames, then random framed traffic
// under several maximum-length settings, checked against an in-bench deframing predictor.
// Depends on lpd_pkg and the length_prefix_deframer_core RTL.
`timescale 1ns / 1ps

module tb_length_prefix_deframer_core;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int IDLE_MAX        = 18;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int FRAME_CAP       = 24;
   localparam int ITEMS_PER_PHASE = 260;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic [7:0]  req_data_byte;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last_in_frame;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   length_prefix_deframer_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_data_byte     (req_data_byte),
      .req_full          (req_full),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last_in_frame (rsp_last_in_frame),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   bit                  in_frame;
   logic [1:0]          hdr_count;
   logic [31:0]         hdr_shift;
   logic [31:0]         payload_left;
   logic [31:0]         limit_len;
   lpd_pkg::result_type deframed_q[$];

   // handshake samples, taken at the falling edge
   bit          req_fire;
   bit          rsp_fire;
   logic [1:0]  seen_kind;
   logic [7:0]  seen_byte;
   logic        seen_last;

   bit          send_idle_on;
   bit          recv_idle_on;
   int          error_count;
   int          items_sent;
   int          results_checked;
   int          settings_used;
   int          cycle_count;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, deframed_q.size());
      $display("TEST FAILED");
      $finish;
   end

   always @(negedge clock) begin
      req_fire  = req_push && !req_full;
      rsp_fire  = rsp_pop && !rsp_empty;
      seen_kind = rsp_result_kind;
      seen_byte = rsp_payload_byte;
      seen_last = rsp_last_in_frame;
   end

   // Expected result for one accepted byte, if it causes one.
   function automatic void deframe_byte(input logic [7:0] value);
      lpd_pkg::result_type r;
      r.kind          = lpd_pkg::KIND_PAYLOAD;
      r.payload_byte  = 8'h00;
      r.last_in_frame = 1'b0;
      if (in_frame) begin
         payload_left    = payload_left - 32'd1;
         r.payload_byte  = value;
         r.last_in_frame = (payload_left == 32'd0);
         if (payload_left == 32'd0)
            in_frame = 1'b0;
         deframed_q.push_back(r);
         return;
      end
      hdr_shift = {hdr_shift[23:0], value};
      if (hdr_count < lpd_pkg::HEADER_BYTES - 1) begin
         hdr_count = hdr_count + 2'd1;
         return;
      end
      hdr_count = 2'd0;
      if (hdr_shift > limit_len) begin
         hdr_shift = 32'd0;
         r.kind    = lpd_pkg::KIND_OVERSIZE;
         deframed_q.push_back(r);
      end else if (hdr_shift == 32'd0) begin
         r.kind          = lpd_pkg::KIND_EMPTY;
         r.last_in_frame = 1'b1;
         deframed_q.push_back(r);
      end else begin
         payload_left = hdr_shift;
         hdr_shift    = 32'd0;
         in_frame     = 1'b1;
      end
   endfunction

   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = send_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= value;
      do @(posedge clock); while (!req_fire);
      deframe_byte(value);
      items_sent++;
   endtask

   task automatic send_header(input logic [31:0] len);
      send_byte(len[31:24]);
      send_byte(len[23:16]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
   endtask

   // Sender holds off until every expected result has been popped.
   task automatic wait_all_results();
      req_push <= 1'b0;
      while (deframed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_max_length(input logic [31:0] value);
      wait_all_results();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_len = value;
      settings_used++;
      @(posedge clock);
   endtask

   // Result side: random stall before each pop while recv_idle_on is set.
   initial begin
      int gap;
      rsp_pop = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         gap = recv_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (!rsp_fire);
      end
   end

   always @(posedge clock) begin : check_results
      lpd_pkg::result_type want;
      if (rsp_fire) begin
         if (deframed_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual kind=%0d byte=%02h last=%0b",
                     $time, seen_kind, seen_byte, seen_last);
         end else begin
            want = deframed_q.pop_front();
            results_checked++;
            if (seen_kind !== want.kind) begin
               error_count++;
               $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                        $time, want.kind, seen_kind);
            end
            if (seen_byte !== want.payload_byte) begin
               error_count++;
               $display("%0t: payload_byte mismatch, expected %02h, actual %02h",
                        $time, want.payload_byte, seen_byte);
            end
            if (seen_last !== want.last_in_frame) begin
               error_count++;
               $display("%0t: last_in_frame mismatch, expected %0b, actual %0b",
                        $time, want.last_in_frame, seen_last);
            end
         end
      end
   end

   task automatic test_empty_frame();
      send_header(32'd0);
   endtask

   task automatic test_payload_frame();
      send_header(32'd2);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   // oversize header under the reset maximum, then the next byte opens a new header
   task automatic test_oversize_resync();
      send_header(lpd_pkg::DEFAULT_MAX_FRAME_LENGTH + 32'd1);
      send_header(32'd1);
      send_byte(8'hA5);
   endtask

   task automatic test_zero_max();
      set_max_length(32'd0);
      send_header(32'd0);
      send_header(32'hFFFF_FFFF);
   endtask

   // Flush a partial header or frame; called at the end of every random phase.
   task automatic realign_stream();
      while (in_frame || hdr_count != 2'd0)
         send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic run_phase(input logic [31:0] max_len, input int n_items);
      int          start;
      int          stretch_end;
      int          pick;
      logic [31:0] cap;
      logic [31:0] len;
      logic [31:0] r;
      set_max_length(max_len);
      start       = items_sent;
      stretch_end = items_sent;
      cap         = (limit_len < FRAME_CAP) ? limit_len : FRAME_CAP;
      while (items_sent - start < n_items) begin
         if (items_sent >= stretch_end) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            stretch_end  = items_sent + $urandom_range(40, 120);
         end
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            wait_all_results();
         end else if (pick < 12 || cap == 32'd0 && pick >= 30) begin
            send_header(32'd0);
         end else if (pick < 22 && limit_len != 32'hFFFF_FFFF) begin
            len = limit_len + 32'd1;
            r   = $urandom;
            if ($urandom_range(0, 1) && r > limit_len)
               len = r;
            send_header(len);
         end else if (pick < 30 && limit_len <= FRAME_CAP) begin
            // noise: arbitrary bytes that break the framing
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end else if (cap != 32'd0) begin
            len = ($urandom_range(0, 3) == 0) ? cap : $urandom_range(1, cap);
            send_header(len);
            repeat (len) send_byte(8'($urandom_range(0, 255)));
         end
      end
      realign_stream();
      wait_all_results();
   endtask

   task automatic test_random_traffic();
      run_phase(32'd0, ITEMS_PER_PHASE);
      run_phase(32'd1, ITEMS_PER_PHASE);
      run_phase($urandom_range(2, 16), ITEMS_PER_PHASE);
      run_phase(32'd32, ITEMS_PER_PHASE);
      run_phase(32'hFFFF_FFFF, ITEMS_PER_PHASE);
      run_phase($urandom_range(32'h0000_1000, 32'hFFFF_FFFE), ITEMS_PER_PHASE);
      run_phase(lpd_pkg::DEFAULT_MAX_FRAME_LENGTH, ITEMS_PER_PHASE);
   endtask

   initial begin
      int i;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_data_byte = 8'h00;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 32'd0;
      in_frame      = 1'b0;
      hdr_count     = 2'd0;
      hdr_shift     = 32'd0;
      payload_left  = 32'd0;
      limit_len     = lpd_pkg::DEFAULT_MAX_FRAME_LENGTH;
      send_idle_on  = 1'b1;
      recv_idle_on  = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_frame();
      test_payload_frame();
      test_oversize_resync();
      test_zero_max();
      test_random_traffic();

      req_push <= 1'b0;
      for (i = 0; i < DRAIN_LIMIT && deframed_q.size() != 0; i++) @(posedge clock);
      if (deframed_q.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived", $time, deframed_q.size());
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d bytes and %0d results over %0d maximum-length settings,",
               items_sent, results_checked, settings_used);
      $display("with empty frames, oversize headers, stream noise and random stalls.");
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* files.f */
hdl/lpd_pkg.sv
hdl/lpd_front.sv
hdl/lpd_queue.sv
hdl/length_prefix_deframer_core.sv
tb/sv/tb_length_prefix_deframer_core.sv
